### hw/rtl/lou_pkg.sv
// Package for the Lion optimizer update block: types, constants and
// floating-point helper functions (rounding, widening, narrowing).
// Depends on nothing; used by every other file of the block except lou_checker.
`timescale 1ns / 1ps

package lou_pkg;

  localparam logic [31:0] FpOne     = 32'h3F80_0000;
  localparam logic [31:0] FpDefNan  = 32'hFFC0_0000;
  localparam logic [31:0] FpQuiet   = 32'h0040_0000;
  localparam logic [30:0] FpInfMag  = 31'h7F80_0000;

  typedef enum logic [2:0] {
    CFG_LR     = 3'd0,
    CFG_BETA1  = 3'd1,
    CFG_BETA2  = 3'd2,
    CFG_DECAY  = 3'd3,
    CFG_TPAIR  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    TP_FP16_FP32 = 3'd0,
    TP_FP16_FP16 = 3'd1,
    TP_BF16_FP32 = 3'd2,
    TP_BF16_BF16 = 3'd3,
    TP_FP32_FP32 = 3'd4
  } tpair_e;

  typedef enum logic [1:0] {
    FMT_FP32 = 2'd0,
    FMT_FP16 = 2'd1,
    FMT_BF16 = 2'd2
  } fmt_e;

  typedef struct packed {
    logic [31:0] lr;
    logic [31:0] beta1;
    logic [31:0] beta2;
    logic [31:0] decay;
    logic [2:0]  tpair;
  } cfg_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic fmt_e param_fmt(input logic [2:0] tp);
    fmt_e f;
    case (tp)
      TP_FP16_FP32, TP_FP16_FP16: f = FMT_FP16;
      TP_BF16_FP32, TP_BF16_BF16: f = FMT_BF16;
      default: f = FMT_FP32;
    endcase
    return f;
  endfunction

  function automatic fmt_e state_fmt(input logic [2:0] tp);
    fmt_e f;
    case (tp)
      TP_FP16_FP16: f = FMT_FP16;
      TP_BF16_BF16: f = FMT_BF16;
      default: f = FMT_FP32;
    endcase
    return f;
  endfunction

  // Rounds a normalized significand (leading one at bit 49) with biased
  // exponent er to fp32, nearest even, with gradual underflow.
  function automatic logic [31:0] round_pack(input logic s, input logic signed [9:0] er,
                                             input logic [49:0] sig);
    logic [9:0]  sh;
    logic [49:0] shd;
    logic        lost;
    logic [23:0] mt;
    logic        g;
    logic        st;
    logic        inc;
    logic [7:0]  ef;
    logic [30:0] w;
    if (er > 10'sd0) begin
      sh = 10'd0;
    end else begin
      sh = 10'(10'sd1 - er);
    end
    if (sh > 10'd50) begin
      sh = 10'd50;
    end
    shd  = sig >> sh;
    lost = (sig & ~({50{1'b1}} << sh)) != 50'd0;
    mt   = shd[49:26];
    g    = shd[25];
    st   = (shd[24:0] != 25'd0) | lost;
    inc  = g & (st | mt[0]);
    ef   = (er > 10'sd0) ? er[7:0] : 8'd0;
    w    = {ef, mt[22:0]} + {30'd0, inc};
    if (er >= 10'sd255) begin
      return {s, FpInfMag};
    end
    return {s, w};
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  p;
    logic [3:0]  n;
    logic [7:0]  e;
    logic [9:0]  mn;
    sign = {h[15], 31'd0};
    ex   = h[14:10];
    man  = h[9:0];
    p    = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) begin
        p = 4'(i);
      end
    end
    n  = 4'd10 - p;
    e  = 8'd113 - {4'd0, n};
    mn = man << n;
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        return sign;
      end
      return sign | {1'b0, e, mn, 13'd0};
    end
    if (ex == 5'h1F) begin
      return sign | {1'b0, 8'hFF, man, 13'd0};
    end
    return sign | {1'b0, {3'd0, ex} + 8'd112, man, 13'd0};
  endfunction

  function automatic logic [31:0] widen(input logic [31:0] v, input fmt_e f);
    logic [31:0] r;
    case (f)
      FMT_FP16: r = half_to_single(v[15:0]);
      FMT_BF16: r = {v[15:0], 16'd0};
      default:  r = v;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] round_shift(input logic [31:0] m, input logic [4:0] sh);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    q    = m >> sh;
    rem  = m & ((32'd1 << sh) - 32'd1);
    half = 32'd1 << (sh - 5'd1);
    if ((rem > half) || ((rem == half) && q[0])) begin
      q = q + 32'd1;
    end
    return q[15:0];
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] x);
    logic [15:0] sign;
    logic [7:0]  ex;
    logic [22:0] man;
    logic signed [9:0] e;
    logic [9:0]  sh;
    sign = {x[31], 15'd0};
    ex   = x[30:23];
    man  = x[22:0];
    e    = $signed({2'b00, ex}) - 10'sd112;
    sh   = 10'(10'sd14 - e);
    if (ex == 8'hFF) begin
      return sign | ((man != 23'd0) ? 16'h7E00 : 16'h7C00);
    end
    if (ex == 8'd0) begin
      return sign;
    end
    if (e >= 10'sd31) begin
      return sign | 16'h7C00;
    end
    if (e <= 10'sd0) begin
      if (sh > 10'd24) begin
        return sign;
      end
      return sign | round_shift({8'd0, 1'b1, man}, sh[4:0]);
    end
    return sign | round_shift({4'd0, e[4:0], man}, 5'd13);
  endfunction

  function automatic logic [15:0] single_to_bf16(input logic [31:0] x);
    logic [31:0] t;
    t = x + 32'h0000_7FFF + {31'd0, x[16]};
    if (is_nan(x)) begin
      return 16'h7FC0;
    end
    return t[31:16];
  endfunction

  function automatic logic [31:0] narrow(input logic [31:0] v, input fmt_e f);
    logic [31:0] r;
    case (f)
      FMT_FP16: r = {16'd0, single_to_half(v)};
      FMT_BF16: r = {16'd0, single_to_bf16(v)};
      default:  r = v;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/lou_cfg_regs.sv
// Configuration register file of the Lion optimizer update block.
// Depends on lou_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps

module lou_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output lou_pkg::cfg_t cfg_o
);

  lou_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lou_pkg::CFG_LR:    cfg_d.lr    = cfg_data_i;
        lou_pkg::CFG_BETA1: cfg_d.beta1 = cfg_data_i;
        lou_pkg::CFG_BETA2: cfg_d.beta2 = cfg_data_i;
        lou_pkg::CFG_DECAY: cfg_d.decay = cfg_data_i;
        lou_pkg::CFG_TPAIR: cfg_d.tpair = cfg_data_i[2:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr    <= 32'h38D1_B717;
      cfg_q.beta1 <= 32'h3F66_6666;
      cfg_q.beta2 <= 32'h3F7D_70A4;
      cfg_q.decay <= 32'd0;
      cfg_q.tpair <= lou_pkg::TP_FP32_FP32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/lou_fp_mul.sv
// Combinational fp32 multiplier, nearest even, subnormals kept.
// Depends on lou_pkg for constants and the shared rounding function.
`timescale 1ns / 1ps

module lou_fp_mul (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  logic        s;
  logic [7:0]  eaa, ebb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [47:0] prod, norm;
  logic [5:0]  lz;
  logic signed [9:0] er;

  assign s      = a_i[31] ^ b_i[31];
  assign nan_a  = lou_pkg::is_nan(a_i);
  assign nan_b  = lou_pkg::is_nan(b_i);
  assign inf_a  = (a_i[30:0] == lou_pkg::FpInfMag);
  assign inf_b  = (b_i[30:0] == lou_pkg::FpInfMag);
  assign zero_a = (a_i[30:0] == 31'd0);
  assign zero_b = (b_i[30:0] == 31'd0);
  assign eaa    = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
  assign ebb    = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
  assign ma     = {a_i[30:23] != 8'd0, a_i[22:0]};
  assign mb     = {b_i[30:23] != 8'd0, b_i[22:0]};
  assign prod   = ma * mb;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (prod[i]) begin
        lz = 6'(47 - i);
      end
    end
  end

  assign norm = prod << lz;
  assign er   = $signed({2'b00, eaa}) + $signed({2'b00, ebb}) - 10'sd126
              - $signed({4'b0000, lz});

  always_comb begin
    if (nan_a) begin
      y_o = a_i | lou_pkg::FpQuiet;
    end else if (nan_b) begin
      y_o = b_i | lou_pkg::FpQuiet;
    end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
      y_o = lou_pkg::FpDefNan;
    end else if (inf_a || inf_b) begin
      y_o = {s, lou_pkg::FpInfMag};
    end else if (zero_a || zero_b) begin
      y_o = {s, 31'd0};
    end else begin
      y_o = lou_pkg::round_pack(s, er, {norm, 2'b00});
    end
  end

endmodule

### hw/rtl/lou_fp_add.sv
// Combinational fp32 adder and subtractor, nearest even, subnormals kept.
// Depends on lou_pkg for constants and the shared rounding function.
`timescale 1ns / 1ps

module lou_fp_add (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [31:0] y_o
);

  logic        sa, sb;
  logic        nan_a, nan_b, inf_a, inf_b;
  logic        swap;
  logic        sl, ss;
  logic [7:0]  el, es, d;
  logic [5:0]  dd;
  logic [23:0] ml, ms;
  logic [49:0] xl, xs, xs_sh, sum, norm;
  logic        lost;
  logic [5:0]  lz;
  logic signed [9:0] er;

  assign sa    = a_i[31];
  assign sb    = b_i[31] ^ sub_i;
  assign nan_a = lou_pkg::is_nan(a_i);
  assign nan_b = lou_pkg::is_nan(b_i);
  assign inf_a = (a_i[30:0] == lou_pkg::FpInfMag);
  assign inf_b = (b_i[30:0] == lou_pkg::FpInfMag);
  assign swap  = (b_i[30:0] > a_i[30:0]);

  always_comb begin
    if (swap) begin
      sl = sb;
      ss = sa;
      el = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
      es = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
      ml = {b_i[30:23] != 8'd0, b_i[22:0]};
      ms = {a_i[30:23] != 8'd0, a_i[22:0]};
    end else begin
      sl = sa;
      ss = sb;
      el = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
      es = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
      ml = {a_i[30:23] != 8'd0, a_i[22:0]};
      ms = {b_i[30:23] != 8'd0, b_i[22:0]};
    end
  end

  assign d    = el - es;
  assign dd   = (d > 8'd50) ? 6'd50 : d[5:0];
  assign xl   = {1'b0, ml, 25'd0};
  assign xs   = {1'b0, ms, 25'd0};
  assign lost = (xs & ~({50{1'b1}} << dd)) != 50'd0;

  always_comb begin
    xs_sh    = xs >> dd;
    xs_sh[0] = xs_sh[0] | lost;
  end

  assign sum = (sl ^ ss) ? (xl - xs_sh) : (xl + xs_sh);

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (sum[i]) begin
        lz = 6'(49 - i);
      end
    end
  end

  assign norm = sum << lz;
  assign er   = $signed({2'b00, el}) + 10'sd1 - $signed({4'b0000, lz});

  always_comb begin
    if (nan_a) begin
      y_o = a_i | lou_pkg::FpQuiet;
    end else if (nan_b) begin
      y_o = b_i | lou_pkg::FpQuiet;
    end else if (inf_a && inf_b && (sa != sb)) begin
      y_o = lou_pkg::FpDefNan;
    end else if (inf_a) begin
      y_o = {sa, lou_pkg::FpInfMag};
    end else if (inf_b) begin
      y_o = {sb, lou_pkg::FpInfMag};
    end else if (sum == 50'd0) begin
      y_o = {sa & sb, 31'd0};
    end else begin
      y_o = lou_pkg::round_pack(sl, er, norm);
    end
  end

endmodule

### hw/rtl/lion_optimizer_update.sv
// Top level of the Lion optimizer update block: six-stage fp32 pipeline.
// Depends on lou_pkg, lou_cfg_regs, lou_fp_mul and lou_fp_add.
`timescale 1ns / 1ps

// One element enters per clock whenever start is high; busy never rises, so
// a new item may follow in every cycle. Each result appears on the result
// ports after passing the six register stages, marked by done_o for exactly one
// cycle, and must be taken then because the receiver cannot stall the block.
// The six register stages hold: widening with the lr*wd product,
// the one-minus-beta subtractions, the multiplies, the interpolation adds, the
// parameter add and the final narrowing. Configuration writes are registered
// and should only be made while no item is in flight.
module lion_optimizer_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] param_in_i,
  input  logic [31:0] grad_in_i,
  input  logic [31:0] momentum_in_i,
  input  logic        is_last_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] param_out_o,
  output logic [31:0] momentum_out_o,
  output logic        is_last_out_o
);

  lou_pkg::cfg_t cfg;
  logic          decay_on;

  logic        s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic        s1_last_q, s2_last_q, s3_last_q, s4_last_q, s5_last_q, s6_last_q;
  logic [31:0] s1_p_q, s1_g_q, s1_m_q, s1_lrwd_q, s1_lrwd_d;
  logic [31:0] s2_p_q, s2_g_q, s2_m_q, s2_b1m_q, s2_b2m_q, s2_aft_q;
  logic [31:0] s2_b1m_d, s2_b2m_d, s2_aft_d;
  logic [31:0] s3_p_q, s3_gb1_q, s3_mb1_q, s3_gb2_q, s3_mb2_q, s3_pa_q;
  logic [31:0] s3_gb1_d, s3_mb1_d, s3_gb2_d, s3_mb2_d, s3_pa_d;
  logic [31:0] s4_p_q, s4_pa_q, s4_c_q, s4_nm_q, s4_c_d, s4_nm_d;
  logic [31:0] s4_upd, s4_base;
  logic [31:0] s5_np_q, s5_nm_q, s5_np_d;
  logic [31:0] s6_p_q, s6_m_q;

  lou_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign busy     = 1'b0;
  assign decay_on = !cfg.decay[31] && (cfg.decay != 32'd0) && !lou_pkg::is_nan(cfg.decay);

  lou_fp_mul u_mul_lrwd (.a_i(cfg.lr), .b_i(cfg.decay), .y_o(s1_lrwd_d));

  lou_fp_add u_sub_b1 (.a_i(lou_pkg::FpOne), .b_i(cfg.beta1), .sub_i(1'b1), .y_o(s2_b1m_d));
  lou_fp_add u_sub_b2 (.a_i(lou_pkg::FpOne), .b_i(cfg.beta2), .sub_i(1'b1), .y_o(s2_b2m_d));
  lou_fp_add u_sub_af (.a_i(lou_pkg::FpOne), .b_i(s1_lrwd_q), .sub_i(1'b1), .y_o(s2_aft_d));

  lou_fp_mul u_mul_gb1 (.a_i(s2_g_q), .b_i(s2_b1m_q),  .y_o(s3_gb1_d));
  lou_fp_mul u_mul_mb1 (.a_i(s2_m_q), .b_i(cfg.beta1), .y_o(s3_mb1_d));
  lou_fp_mul u_mul_gb2 (.a_i(s2_g_q), .b_i(s2_b2m_q),  .y_o(s3_gb2_d));
  lou_fp_mul u_mul_mb2 (.a_i(s2_m_q), .b_i(cfg.beta2), .y_o(s3_mb2_d));
  lou_fp_mul u_mul_pa  (.a_i(s2_p_q), .b_i(s2_aft_q),  .y_o(s3_pa_d));

  lou_fp_add u_add_c  (.a_i(s3_gb1_q), .b_i(s3_mb1_q), .sub_i(1'b0), .y_o(s4_c_d));
  lou_fp_add u_add_nm (.a_i(s3_gb2_q), .b_i(s3_mb2_q), .sub_i(1'b0), .y_o(s4_nm_d));

  assign s4_upd  = {~s4_c_q[31], cfg.lr[30:0]};
  assign s4_base = decay_on ? s4_pa_q : s4_p_q;

  lou_fp_add u_add_np (.a_i(s4_base), .b_i(s4_upd), .sub_i(1'b0), .y_o(s5_np_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_p_q    <= lou_pkg::widen(param_in_i, lou_pkg::param_fmt(cfg.tpair));
    s1_g_q    <= lou_pkg::widen(grad_in_i, lou_pkg::param_fmt(cfg.tpair));
    s1_m_q    <= lou_pkg::widen(momentum_in_i, lou_pkg::state_fmt(cfg.tpair));
    s1_lrwd_q <= s1_lrwd_d;
    s1_last_q <= is_last_i;

    s2_p_q    <= s1_p_q;
    s2_g_q    <= s1_g_q;
    s2_m_q    <= s1_m_q;
    s2_b1m_q  <= s2_b1m_d;
    s2_b2m_q  <= s2_b2m_d;
    s2_aft_q  <= s2_aft_d;
    s2_last_q <= s1_last_q;

    s3_p_q    <= s2_p_q;
    s3_gb1_q  <= s3_gb1_d;
    s3_mb1_q  <= s3_mb1_d;
    s3_gb2_q  <= s3_gb2_d;
    s3_mb2_q  <= s3_mb2_d;
    s3_pa_q   <= s3_pa_d;
    s3_last_q <= s2_last_q;

    s4_p_q    <= s3_p_q;
    s4_pa_q   <= s3_pa_q;
    s4_c_q    <= s4_c_d;
    s4_nm_q   <= s4_nm_d;
    s4_last_q <= s3_last_q;

    s5_np_q   <= s5_np_d;
    s5_nm_q   <= s4_nm_q;
    s5_last_q <= s4_last_q;

    s6_p_q    <= lou_pkg::narrow(s5_np_q, lou_pkg::param_fmt(cfg.tpair));
    s6_m_q    <= lou_pkg::narrow(s5_nm_q, lou_pkg::state_fmt(cfg.tpair));
    s6_last_q <= s5_last_q;
  end

  assign done_o         = s6_v_q;
  assign param_out_o    = s6_p_q;
  assign momentum_out_o = s6_m_q;
  assign is_last_out_o  = s6_last_q;

endmodule

### hw/rtl/lou_checker.sv
// Port-level checker for the Lion optimizer update block, with its bind.
// Depends only on the ports of lion_optimizer_update.
`timescale 1ns / 1ps

module lou_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        is_last_i,
  input logic        done_o,
  input logic        is_last_out_o
);

  a_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o)
    else $error("start transfer without a result six cycles later");

  a_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6))
    else $error("result without a start transfer six cycles before");

  a_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_last_out_o == $past(is_last_i, 6)))
    else $error("end-of-tensor mark does not follow its item");

  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised although the pipeline never stalls");

endmodule

bind lion_optimizer_update lou_checker u_lou_checker (.*);
